[design/fr_pkg.sv]
// frame reassembler package: command, event and position codes, header constants
// and parameter defaults; used by frame_reassembler
package fr_pkg;

  localparam int FR_BUFFER_BYTES    = 2048;
  localparam int FR_MAX_FRAME_BYTES = 512;
  localparam int HDR_BYTES          = 4;
  localparam logic [1:0] KIND_MASK  = 2'h3;

  typedef enum logic [1:0] {
    CMD_FRAME      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_LINK_RESET = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_READY    = 2'd1,
    EV_IGNORED  = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    POS_ONLY  = 2'd0,
    POS_FIRST = 2'd1,
    POS_CONT  = 2'd2,
    POS_LAST  = 2'd3
  } pos_t;

  typedef enum logic [1:0] {
    RD_NONE   = 2'd0,
    RD_SINGLE = 2'd1,
    RD_BANK   = 2'd2
  } rd_sel_t;

endpackage

[design/frame_reassembler.sv]
// frame reassembler top level: header checks, two-bank message store and
// single-frame store, registered result stage; depends on fr_pkg
//
// Usage: the input channel (in_valid / in_stall) carries one command beat per
// cycle when not stalled: frame bytes (header first, in_frame_end on the last byte), reads of
// the ready message at in_read_index, or a link reset that closes any open
// reassembly and drops a partly received frame. Each accepted beat gives one
// result beat on the output channel (out_valid / out_stall) with the event,
// the length of the most recent ready message and, for a read, the byte.
// Throughput is one beat per cycle while not stalled: every beat does at most one store write
// or one store read, and state updates finish within the beat's cycle.
// The result is registered at the edge that accepts the beat, together with the
// synchronous store read data.
// When the receiver stalls, the waiting result holds and in_stall is raised
// in the same cycle, so no beat is taken until the result moves on.
// Reset clears the control state (bank select, lengths, open flag, byte count,
// header) at once; the byte stores are not cleared and need no clearing pass.
module frame_reassembler #(
  parameter int BUFFER_BYTES    = fr_pkg::FR_BUFFER_BYTES,
  parameter int MAX_FRAME_BYTES = fr_pkg::FR_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic [10:0] in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [11:0] out_message_length,
  output logic [7:0]  out_read_data
);

  localparam int BANK_DEPTH = 2 * BUFFER_BYTES;
  localparam int BA_W       = $clog2(BANK_DEPTH);
  localparam int SA_W       = $clog2(MAX_FRAME_BYTES);
  localparam int CNT_W      = $clog2(MAX_FRAME_BYTES + 2);
  localparam int LEN_MAX    = (BUFFER_BYTES > MAX_FRAME_BYTES) ? BUFFER_BYTES : MAX_FRAME_BYTES;
  localparam int LEN_W      = $clog2(LEN_MAX + 1);

  logic [7:0] bank_mem   [BANK_DEPTH];
  logic [7:0] single_mem [MAX_FRAME_BYTES];

  logic             active_bank_r, active_bank_nxt;
  logic [LEN_W-1:0] committed_r, committed_nxt;
  logic             open_r, open_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      hdr_len_r, hdr_len_nxt;
  logic [7:0]       hdr_flags_r, hdr_flags_nxt;
  logic             from_single_r, from_single_nxt;
  logic [LEN_W-1:0] ready_len_r, ready_len_nxt;

  logic                out_valid_r, out_valid_nxt;
  fr_pkg::event_t      out_event_r, out_event_nxt;
  logic [11:0]         out_len_r, out_len_nxt;
  fr_pkg::rd_sel_t     rd_sel_r, rd_sel_nxt;
  logic [7:0]          bank_rdata_r, single_rdata_r;

  logic            accept;
  logic            bank_we, single_we, bank_re, single_re;
  logic [BA_W-1:0] bank_waddr, bank_raddr;
  logic [SA_W-1:0] single_waddr, single_raddr;

  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      off32, cont32, waddr32, raddr32, sum32, len32, total32, rl32;
  logic [1:0]       kind;
  fr_pkg::pos_t     pos;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    active_bank_nxt = active_bank_r;
    committed_nxt   = committed_r;
    open_nxt        = open_r;
    cnt_nxt         = cnt_r;
    hdr_len_nxt     = hdr_len_r;
    hdr_flags_nxt   = hdr_flags_r;
    from_single_nxt = from_single_r;
    ready_len_nxt   = ready_len_r;
    out_event_nxt   = fr_pkg::EV_NONE;
    rd_sel_nxt      = fr_pkg::RD_NONE;
    bank_we         = 1'b0;
    single_we       = 1'b0;
    bank_re         = 1'b0;
    single_re       = 1'b0;
    kind            = hdr_flags_r[1:0] & fr_pkg::KIND_MASK;
    pos             = fr_pkg::pos_t'(hdr_flags_r[3:2]);
    cnt_inc         = (32'(cnt_r) <= 32'(MAX_FRAME_BYTES)) ? cnt_r + CNT_W'(1) : cnt_r;
    off32           = 32'(cnt_r) - 32'(fr_pkg::HDR_BYTES);
    cont32          = 32'(committed_r) + off32;
    len32           = 32'(hdr_len_r);
    sum32           = 32'(committed_r) + len32;
    total32         = 32'(cnt_inc);
    waddr32         = '0;
    raddr32         = '0;

    unique case (fr_pkg::cmd_t'(in_command))
      fr_pkg::CMD_FRAME: begin
        if (cnt_r == CNT_W'(0)) begin
          hdr_len_nxt[7:0] = in_data_byte;
        end else if (cnt_r == CNT_W'(1)) begin
          hdr_len_nxt[15:8] = in_data_byte;
        end else if (cnt_r == CNT_W'(2)) begin
          hdr_flags_nxt = in_data_byte;
        end else if (32'(cnt_r) >= 32'(fr_pkg::HDR_BYTES)
                     && 32'(cnt_r) <= 32'(MAX_FRAME_BYTES) && kind == 2'd0) begin
          unique case (pos)
            fr_pkg::POS_ONLY: begin
              single_we = 1'b1;
            end
            fr_pkg::POS_FIRST: begin
              if (off32 < 32'(BUFFER_BYTES)) begin
                bank_we = 1'b1;
                waddr32 = (active_bank_r ? 32'd0 : 32'(BUFFER_BYTES)) + off32;
              end
            end
            default: begin
              if (open_r && cont32 < 32'(BUFFER_BYTES)) begin
                bank_we = 1'b1;
                waddr32 = (active_bank_r ? 32'(BUFFER_BYTES) : 32'd0) + cont32;
              end
            end
          endcase
        end
        cnt_nxt = cnt_inc;
        if (in_frame_end) begin
          cnt_nxt       = '0;
          hdr_len_nxt   = '0;
          hdr_flags_nxt = '0;
          if (total32 < 32'(fr_pkg::HDR_BYTES) || total32 > 32'(MAX_FRAME_BYTES)
              || total32 != len32 + 32'(fr_pkg::HDR_BYTES) || kind != 2'd0) begin
            out_event_nxt = fr_pkg::EV_IGNORED;
          end else begin
            unique case (pos)
              fr_pkg::POS_ONLY: begin
                open_nxt        = 1'b0;
                from_single_nxt = 1'b1;
                ready_len_nxt   = len32[LEN_W-1:0];
                out_event_nxt   = fr_pkg::EV_READY;
              end
              fr_pkg::POS_FIRST: begin
                if (len32 > 32'(BUFFER_BYTES)) begin
                  open_nxt      = 1'b0;
                  committed_nxt = '0;
                  out_event_nxt = fr_pkg::EV_OVERFLOW;
                end else begin
                  active_bank_nxt = !active_bank_r;
                  committed_nxt   = len32[LEN_W-1:0];
                  open_nxt        = 1'b1;
                end
              end
              default: begin
                if (!open_r) begin
                  out_event_nxt = fr_pkg::EV_IGNORED;
                end else if (sum32 > 32'(BUFFER_BYTES)) begin
                  open_nxt      = 1'b0;
                  out_event_nxt = fr_pkg::EV_OVERFLOW;
                end else begin
                  committed_nxt = sum32[LEN_W-1:0];
                  if (pos == fr_pkg::POS_LAST) begin
                    open_nxt        = 1'b0;
                    from_single_nxt = 1'b0;
                    ready_len_nxt   = sum32[LEN_W-1:0];
                    out_event_nxt   = fr_pkg::EV_READY;
                  end
                end
              end
            endcase
          end
        end
      end
      fr_pkg::CMD_READ: begin
        if (32'(in_read_index) < 32'(ready_len_r)) begin
          if (from_single_r) begin
            if (32'(in_read_index) < 32'(MAX_FRAME_BYTES)) begin
              single_re  = 1'b1;
              rd_sel_nxt = fr_pkg::RD_SINGLE;
              raddr32    = 32'(in_read_index);
            end
          end else if (32'(in_read_index) < 32'(BUFFER_BYTES)) begin
            bank_re    = 1'b1;
            rd_sel_nxt = fr_pkg::RD_BANK;
            raddr32    = ((open_r ^ active_bank_r) ? 32'(BUFFER_BYTES) : 32'd0)
                         + 32'(in_read_index);
          end
        end
      end
      fr_pkg::CMD_LINK_RESET: begin
        open_nxt      = 1'b0;
        cnt_nxt       = '0;
        hdr_len_nxt   = '0;
        hdr_flags_nxt = '0;
      end
      default: begin
      end
    endcase

    rl32        = 32'(ready_len_nxt);
    out_len_nxt = rl32[11:0];
  end

  assign bank_waddr   = waddr32[BA_W-1:0];
  assign bank_raddr   = raddr32[BA_W-1:0];
  assign single_waddr = off32[SA_W-1:0];
  assign single_raddr = raddr32[SA_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && bank_we) begin
      bank_mem[bank_waddr] <= in_data_byte;
    end
    if (accept && bank_re) begin
      bank_rdata_r <= bank_mem[bank_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && single_we) begin
      single_mem[single_waddr] <= in_data_byte;
    end
    if (accept && single_re) begin
      single_rdata_r <= single_mem[single_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bank_r <= 1'b0;
      committed_r   <= '0;
      open_r        <= 1'b0;
      cnt_r         <= '0;
      hdr_len_r     <= '0;
      hdr_flags_r   <= '0;
      from_single_r <= 1'b0;
      ready_len_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        active_bank_r <= active_bank_nxt;
        committed_r   <= committed_nxt;
        open_r        <= open_nxt;
        cnt_r         <= cnt_nxt;
        hdr_len_r     <= hdr_len_nxt;
        hdr_flags_r   <= hdr_flags_nxt;
        from_single_r <= from_single_nxt;
        ready_len_r   <= ready_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_event_r <= out_event_nxt;
      out_len_r   <= out_len_nxt;
      rd_sel_r    <= rd_sel_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_event_r;
  assign out_message_length = out_len_r;

  always_comb begin
    case (rd_sel_r)
      fr_pkg::RD_BANK:   out_read_data = bank_rdata_r;
      fr_pkg::RD_SINGLE: out_read_data = single_rdata_r;
      default:           out_read_data = 8'd0;
    endcase
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_committed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> 32'(committed_r) <= 32'(BUFFER_BYTES))
    else $error("open reassembly beyond buffer size");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_FRAME_BYTES) + 32'd1)
    else $error("frame byte count past saturation");

  a_link_reset: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == fr_pkg::CMD_LINK_RESET |=> !open_r && cnt_r == '0)
    else $error("link reset left reassembly or frame open");

endmodule
